[rtl/core/lxr_pkg.sv]
// Package: types, character codes and helper functions of the line lexer.
package lxr_pkg;

  localparam int unsigned ColW  = 13;
  localparam int unsigned LineW = 24;
  localparam int unsigned CharW = 8;
  localparam int unsigned KwW   = 32;

  localparam logic [ColW-1:0] MaxLine = ColW'(4096);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [CharW-1:0] CharLowA   = 8'h61;
  localparam logic [CharW-1:0] CharLowZ   = 8'h7A;
  localparam logic [CharW-1:0] CharUpA    = 8'h41;
  localparam logic [CharW-1:0] CharUpZ    = 8'h5A;
  localparam logic [CharW-1:0] CharUscore = 8'h5F;
  localparam logic [CharW-1:0] CharDig0   = 8'h30;
  localparam logic [CharW-1:0] CharDig9   = 8'h39;
  localparam logic [CharW-1:0] CharComma  = 8'h2C;
  localparam logic [CharW-1:0] CharLBrace = 8'h7B;
  localparam logic [CharW-1:0] CharRBrace = 8'h7D;
  localparam logic [CharW-1:0] CharLParen = 8'h28;
  localparam logic [CharW-1:0] CharRParen = 8'h29;
  localparam logic [CharW-1:0] CharPoint  = 8'h2E;
  localparam logic [CharW-1:0] CharSemi   = 8'h3B;
  localparam logic [CharW-1:0] CharColon  = 8'h3A;
  localparam logic [CharW-1:0] CharEqual  = 8'h3D;

  localparam logic [15:0]    KwFn   = 16'h666E;
  localparam logic [KwW-1:0] KwType = 32'h74797065;

  typedef enum logic [3:0] {
    KIND_NAME      = 4'd0,
    KIND_NUMBER    = 4'd1,
    KIND_COMMA     = 4'd2,
    KIND_LBRACE    = 4'd3,
    KIND_RBRACE    = 4'd4,
    KIND_LBRACKET  = 4'd5,
    KIND_RBRACKET  = 4'd6,
    KIND_POINT     = 4'd7,
    KIND_SEMICOLON = 4'd8,
    KIND_COLON     = 4'd9,
    KIND_EQUAL     = 4'd10,
    KIND_FN        = 4'd11,
    KIND_TYPE      = 4'd12
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_NUM  = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_of_line;
    logic [LineW-1:0] line_number;
  } char_req_t;

  typedef struct packed {
    tok_kind_e        kind;
    logic [LineW-1:0] line;
    logic [ColW-1:0]  column;
    logic [ColW-1:0]  length;
    logic             last;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } scan_res_t;

  function automatic logic [ColW-1:0] sat_inc(logic [ColW-1:0] v);
    return (v >= MaxLine) ? MaxLine : v + 1'b1;
  endfunction

  function automatic logic is_symbol(logic [CharW-1:0] c);
    return (c == CharComma) || (c == CharLBrace) || (c == CharRBrace) ||
           (c == CharLParen) || (c == CharRParen) || (c == CharPoint) ||
           (c == CharSemi) || (c == CharColon) || (c == CharEqual);
  endfunction

  function automatic tok_kind_e symbol_kind(logic [CharW-1:0] c);
    tok_kind_e k;
    unique case (c)
      CharComma:  k = KIND_COMMA;
      CharLBrace: k = KIND_LBRACE;
      CharRBrace: k = KIND_RBRACE;
      CharLParen: k = KIND_LBRACKET;
      CharRParen: k = KIND_RBRACKET;
      CharPoint:  k = KIND_POINT;
      CharSemi:   k = KIND_SEMICOLON;
      CharColon:  k = KIND_COLON;
      CharEqual:  k = KIND_EQUAL;
      default:    k = KIND_NAME;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/lxr_in_if.sv]
// Interface: character request channel into the line lexer.
interface lxr_in_if;
  import lxr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_line;
  logic [LineW-1:0] line_number;

  modport source (output valid, output char_code, output end_of_line,
                  output line_number, input ready);
  modport sink   (input valid, input char_code, input end_of_line,
                  input line_number, output ready);
endinterface

[rtl/core/lxr_out_if.sv]
// Interface: token request channel out of the line lexer.
interface lxr_out_if;
  import lxr_pkg::*;

  logic             valid;
  logic             ready;
  logic [3:0]       token_kind;
  logic [LineW-1:0] token_line;
  logic [ColW-1:0]  token_column;
  logic [ColW-1:0]  token_length;
  logic             last;

  modport source (output valid, output token_kind, output token_line,
                  output token_column, output token_length, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_line,
                  input token_column, input token_length, input last,
                  output ready);
endinterface

[rtl/core/lxr_scan.sv]
// Scanner: per-character token state and up to two tokens per character.
module lxr_scan
  import lxr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  char_req_t req_i,
  output scan_res_t res_o
);

  scan_mode_e       mode_q, mode_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ColW-1:0]  start_q, start_d;
  logic [ColW-1:0]  len_q, len_d;
  logic [LineW-1:0] line_q, line_d;
  logic [KwW-1:0]   kw_q, kw_d;

  logic             pend;
  tok_t             flush_tok;
  tok_t             sym_tok;
  logic [ColW-1:0]  col_inc;
  scan_mode_e       cls;
  logic [CharW-1:0] c;

  assign c       = req_i.char_code;
  assign col_inc = sat_inc(col_q);
  assign pend    = (mode_q == MODE_NAME) || (mode_q == MODE_NUM);

  always_comb begin
    if (((c >= CharLowA) && (c <= CharLowZ)) || ((c >= CharUpA) && (c <= CharUpZ)) ||
        (c == CharUscore)) begin
      cls = MODE_NAME;
    end else if ((c >= CharDig0) && (c <= CharDig9)) begin
      cls = MODE_NUM;
    end else begin
      cls = MODE_IDLE;
    end
  end

  always_comb begin
    flush_tok        = '0;
    flush_tok.line   = line_q;
    flush_tok.column = start_q;
    flush_tok.length = len_q;
    priority if (mode_q == MODE_NUM) begin
      flush_tok.kind = KIND_NUMBER;
    end else if ((len_q == ColW'(2)) && (kw_q[15:0] == KwFn)) begin
      flush_tok.kind = KIND_FN;
    end else if ((len_q == ColW'(4)) && (kw_q == KwType)) begin
      flush_tok.kind = KIND_TYPE;
    end else begin
      flush_tok.kind = KIND_NAME;
    end

    sym_tok        = '0;
    sym_tok.kind   = symbol_kind(c);
    sym_tok.line   = req_i.line_number;
    sym_tok.column = col_inc;
    sym_tok.length = ColW'(1);
  end

  always_comb begin
    mode_d  = mode_q;
    col_d   = col_q;
    start_d = start_q;
    len_d   = len_q;
    line_d  = line_q;
    kw_d    = kw_q;
    res_o   = '0;

    if (req_i.end_of_line) begin
      col_d  = '0;
      mode_d = MODE_IDLE;
      if (pend) begin
        res_o.count = 2'd1;
        res_o.tok0  = flush_tok;
      end
    end else begin
      col_d = col_inc;
      if ((cls != MODE_IDLE) && (cls == mode_q)) begin
        len_d = sat_inc(len_q);
        kw_d  = {kw_q[KwW-CharW-1:0], c};
      end else begin
        mode_d = cls;
        if (cls != MODE_IDLE) begin
          start_d = col_inc;
          len_d   = ColW'(1);
          line_d  = req_i.line_number;
          kw_d    = KwW'(c);
        end
        if (pend && (cls == MODE_IDLE) && is_symbol(c)) begin
          res_o.count = 2'd2;
          res_o.tok0  = flush_tok;
          res_o.tok1  = sym_tok;
        end else if (pend) begin
          res_o.count = 2'd1;
          res_o.tok0  = flush_tok;
        end else if ((cls == MODE_IDLE) && is_symbol(c)) begin
          res_o.count = 2'd1;
          res_o.tok0  = sym_tok;
        end
      end
    end

    unique case (res_o.count)
      2'd1:    res_o.tok0.last = 1'b1;
      2'd2:    res_o.tok1.last = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      col_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      line_q  <= '0;
      kw_q    <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      col_q   <= col_d;
      start_q <= start_d;
      len_q   <= len_d;
      line_q  <= line_d;
      kw_q    <= kw_d;
    end
  end

endmodule

[rtl/core/line_lexer_top.sv]
// Top level: input register, scanner and token queue of the line lexer.
//
// Usage: source characters enter on in_i, one request per character or
// end-of-line marker; tokens leave on out_o with kind, line, column,
// length and a last flag on the final token a request causes.
// Both channels use valid/ready; a request moves when both are high.
// An accepted character waits in the input register and is scanned from it
// once the queue has room; its tokens are written into a four-entry queue
// and the first token is offered from the queue registers.
// Throughput: one character per cycle while the queue has room. The queue
// drains one token per cycle while out_o.ready is high, and a character
// that gives two tokens fills two entries; the scanner proceeds while the
// queue has room for two tokens. When the receiver stalls, the queue fills
// and in_i.ready drops once the input register holds a character that
// cannot be scanned. Reset clears the scan state (no pending token, column
// zero), the valid flag of the input register and the queue.
module line_lexer_top
  import lxr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lxr_in_if.sink    in_i,
  lxr_out_if.source out_o
);

  logic              s1_valid_q;
  char_req_t         s1_q;
  logic              fire;
  logic              pop;
  scan_res_t         res;

  tok_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoCw-1:0] cnt_q;
  tok_t              head;

  assign fire       = s1_valid_q && (cnt_q <= FifoCw'(FifoDepth - 2));
  assign in_i.ready = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q.char_code   <= in_i.char_code;
      s1_q.end_of_line <= in_i.end_of_line;
      s1_q.line_number <= in_i.line_number;
    end
  end

  lxr_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (s1_q),
    .res_o  (res)
  );

  assign pop = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (fire) begin
        wptr_q <= wptr_q + FifoAw'(res.count);
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (fire ? FifoCw'(res.count) : FifoCw'(0)) - FifoCw'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && (res.count != 2'd0)) begin
      mem_q[wptr_q] <= res.tok0;
    end
    if (fire && (res.count == 2'd2)) begin
      mem_q[wptr_q + 1'b1] <= res.tok1;
    end
  end

  assign head               = mem_q[rptr_q];
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.token_kind   = head.kind;
  assign out_o.token_line   = head.line;
  assign out_o.token_column = head.column;
  assign out_o.token_length = head.length;
  assign out_o.last         = head.last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCw'(FifoDepth))
    else $error("token queue count beyond depth");

  a_eol_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_q.end_of_line) |-> (res.count != 2'd2))
    else $error("end of line produced two tokens");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res.count == 2'd2)) |-> (!res.tok0.last && res.tok1.last))
    else $error("last flag misplaced on token pair");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res.count != 2'd0)) |=> out_o.valid)
    else $error("pushed token not offered");

endmodule
